@@ src/drt_pkg.sv @@
package drt_pkg;

  localparam int MaxRanges = 64;
  localparam int IdxW = $clog2(MaxRanges);
  localparam int CntW = $clog2(MaxRanges + 1);

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpMatch = 2'd1;
  localparam logic [1:0] OpList  = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  // table write data select
  localparam logic [1:0] WselMerge = 2'd0;
  localparam logic [1:0] WselCopy  = 2'd1;
  localparam logic [1:0] WselNew   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, reset scan index
    logic scan;      // evaluate entry read at idx, idx++
    logic rd;        // issue read of entry at ra
    logic wr;        // write entry
    logic [1:0] wsel;  // merged, shift/compact copy or new entry
    logic inc;       // idx++
    logic dec;       // idx--
    logic set_hi1;   // idx <= hi+1
    logic set_last;  // idx <= count, stop <= 1
    logic fin_add;   // apply count change for add
    logic clr;       // count <= 0
    logic out_ld;    // load output register
  } drt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic empty_add;
    logic idx_end;   // idx == count
    logic found;
    logic stop;      // match/list early exit
    logic full;
    logic pos_hit;   // shift reached insert position
    logic drop_nz;
  } drt_sts_t;

endpackage

@@ src/drt_ctrl.sv @@
module drt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output drt_pkg::drt_cmd_t cmd,
  input  drt_pkg::drt_sts_t sts
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_WAIT  = 10'b0000000100,
    S_EVAL  = 10'b0000001000,
    S_CMPR  = 10'b0000010000,
    S_CMPW  = 10'b0000100000,
    S_SHFR  = 10'b0001000000,
    S_SHFW  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE) && !out_valid;

  logic out_v;
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (cmd.out_ld) out_v <= 1'b1;
    else if (out_ready) out_v <= 1'b0;
  end
  assign out_valid = out_v;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.op == drt_pkg::OpClear) begin
          cmd.clr = 1'b1;
          state_next = S_FIN;
        end else if (sts.op == drt_pkg::OpAdd && sts.empty_add) begin
          state_next = S_FIN;
        end else if (sts.idx_end || sts.stop) begin
          state_next = S_EVAL;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.scan = 1'b1;
        state_next = S_SCAN;
      end
      S_EVAL: begin
        if (sts.op != drt_pkg::OpAdd) begin
          state_next = S_FIN;
        end else if (sts.found) begin
          cmd.wr = 1'b1;
          cmd.wsel = drt_pkg::WselMerge;
          cmd.set_hi1 = 1'b1;
          state_next = sts.drop_nz ? S_CMPR : S_FIN;
        end else if (sts.full) begin
          state_next = S_FIN;
        end else begin
          cmd.set_last = 1'b1;
          state_next = S_SHFR;
        end
      end
      S_CMPR: begin
        if (sts.idx_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_CMPW;
        end
      end
      S_CMPW: begin
        cmd.wr = 1'b1;
        cmd.wsel = drt_pkg::WselCopy;
        cmd.inc = 1'b1;
        state_next = S_CMPR;
      end
      S_SHFR: begin
        if (sts.pos_hit) begin
          cmd.wr = 1'b1;
          cmd.wsel = drt_pkg::WselNew;
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_SHFW;
        end
      end
      S_SHFW: begin
        cmd.wr = 1'b1;
        cmd.wsel = drt_pkg::WselCopy;
        cmd.dec = 1'b1;
        state_next = S_SHFR;
      end
      S_FIN: begin
        cmd.fin_add = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_ld = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/drt_dp.sv @@
module drt_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        op,
  input  logic [31:0]       start_req,
  input  logic [31:0]       length,
  input  logic [31:0]       limit_end,
  input  drt_pkg::drt_cmd_t cmd,
  output drt_pkg::drt_sts_t sts,
  output logic              covered,
  output logic [31:0]       segment_length,
  output logic              segment_marked,
  output logic              table_full,
  output logic [6:0]        range_count
);

  localparam int IW = drt_pkg::IdxW;
  localparam int CW = drt_pkg::CntW;

  logic [31:0] mem_s [drt_pkg::MaxRanges];
  logic [31:0] mem_e [drt_pkg::MaxRanges];
  logic [31:0] rd_s, rd_e;

  logic [1:0]  r_op;
  logic [31:0] r_s, r_e, r_lim;
  logic [CW-1:0] count, idx, lo, hi, pos;
  logic found, stop, cov, mark, full_r;
  logic [31:0] seg;
  logic [31:0] m_s, m_e;   // merged range

  logic [32:0] sum;
  assign sum = {1'b0, start_req} + {1'b0, length};

  logic [CW-1:0] drop;
  assign drop = hi - lo;

  // read address: scan/compact use idx, shift reads idx-1
  logic [CW-1:0] ra;
  assign ra = (cmd.rd && r_op == drt_pkg::OpAdd && !found && stop) ? idx - 1'b1 : idx;

  logic [CW-1:0] wa;
  logic [31:0] wd_s, wd_e;
  always_comb begin
    unique case (cmd.wsel)
      drt_pkg::WselMerge: begin wa = lo; wd_s = m_s; wd_e = m_e; end
      drt_pkg::WselCopy: begin wa = found ? idx - drop : idx; wd_s = rd_s; wd_e = rd_e; end
      default: begin wa = idx; wd_s = r_s; wd_e = r_e; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_s <= mem_s[ra[IW-1:0]];
      rd_e <= mem_e[ra[IW-1:0]];
    end
    if (cmd.wr) begin
      mem_s[wa[IW-1:0]] <= wd_s;
      mem_e[wa[IW-1:0]] <= wd_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
      found <= 1'b0;
      stop <= 1'b0;
    end else begin
      if (cmd.load) begin
        r_op <= op;
        r_s <= start_req;
        r_e <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        r_lim <= limit_end;
        idx <= '0;
        found <= 1'b0;
        cov <= 1'b0;
        mark <= 1'b0;
        full_r <= 1'b0;
        seg <= (limit_end > start_req) ? limit_end - start_req : 32'd0;
        stop <= (op == drt_pkg::OpList) && (limit_end <= start_req);
        pos <= count;
      end
      if (cmd.scan) begin
        idx <= idx + 1'b1;
        unique case (r_op)
          drt_pkg::OpAdd: begin
            if (rd_s <= r_e && rd_e >= r_s) begin
              if (!found) begin
                lo <= idx;
                m_s <= (rd_s < r_s) ? rd_s : r_s;
              end
              found <= 1'b1;
              hi <= idx;
              m_e <= (rd_e > r_e) ? rd_e : r_e;
            end
            if (rd_s > r_s && pos == count) pos <= idx;
          end
          drt_pkg::OpMatch: begin
            if (rd_s <= r_s && r_e <= rd_e) begin cov <= 1'b1; stop <= 1'b1; end
            else if (rd_s > r_s) stop <= 1'b1;
          end
          drt_pkg::OpList: begin
            if (rd_s <= r_s && rd_e > r_s) begin
              seg <= ((r_lim < rd_e) ? r_lim : rd_e) - r_s;
              mark <= 1'b1; stop <= 1'b1;
            end else if (rd_s > r_s) begin
              seg <= ((r_lim < rd_s) ? r_lim : rd_s) - r_s;
              stop <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.set_hi1) idx <= hi + 1'b1;
      if (cmd.set_last) begin idx <= count; stop <= 1'b1; end
      if (cmd.inc) idx <= idx + 1'b1;
      if (cmd.dec) idx <= idx - 1'b1;
      if (cmd.clr) count <= '0;
      if (cmd.fin_add && r_op == drt_pkg::OpAdd && r_e != r_s) begin
        if (found) count <= count - drop;
        else if (count >= CW'(drt_pkg::MaxRanges)) full_r <= 1'b1;
        else count <= count + 1'b1;
      end
    end
  end

  assign sts.op        = r_op;
  assign sts.empty_add = (r_e == r_s);
  assign sts.idx_end   = (idx == count);
  assign sts.found     = found;
  assign sts.stop      = stop && (r_op != drt_pkg::OpAdd);
  assign sts.full      = (count >= CW'(drt_pkg::MaxRanges));
  assign sts.pos_hit   = (idx == pos);
  assign sts.drop_nz   = (drop != '0);

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      covered        <= (r_op == drt_pkg::OpMatch) && cov;
      segment_length <= (r_op == drt_pkg::OpList) ? seg : 32'd0;
      segment_marked <= (r_op == drt_pkg::OpList) && mark;
      table_full     <= full_r;
      range_count    <= 7'(count);
    end
  end

endmodule

@@ src/dirty_range_tracker.sv @@
// Flow: clear and empty add skip the table scan; other ops scan up to N
//   stored ranges (N <= 64), and an add may then compact or insert-shift
//   the table.
// Throughput: one word at a time; the next word is taken after the result
//   register empties. Cost is set by the single-port range table scan.
// Reset: synchronous, active high; count cleared, table contents left as is.
module dirty_range_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tuser: op[1:0]
  input  logic [1:0]  s_tuser,
  // tdata: start_req[31:0], length[63:32], limit_end[95:64]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: covered[0], segment_length[32:1], segment_marked[33],
  //   table_full[34], range_count[41:35], pad to 48
  output logic [47:0] m_tdata
);

  drt_pkg::drt_cmd_t cmd;
  drt_pkg::drt_sts_t sts;
  logic        covered, segment_marked, table_full;
  logic [31:0] segment_length;
  logic [6:0]  range_count;

  drt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd(cmd), .sts(sts)
  );

  drt_dp u_dp (
    .clk(clk), .rst(rst),
    .op(s_tuser), .start_req(s_tdata[31:0]),
    .length(s_tdata[63:32]), .limit_end(s_tdata[95:64]),
    .cmd(cmd), .sts(sts),
    .covered(covered), .segment_length(segment_length),
    .segment_marked(segment_marked), .table_full(table_full),
    .range_count(range_count)
  );

  assign m_tdata = {6'd0, range_count, table_full, segment_marked,
                    segment_length, covered};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [1:0]   s_tuser;
  logic [95:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;

  dirty_range_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  typedef struct packed {
    logic [6:0]  range_count;
    logic        table_full;
    logic        segment_marked;
    logic [31:0] segment_length;
    logic        covered;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] start_req;
    logic [31:0] length;
    logic [31:0] limit_end;
    bit          fixed;     // typed-in expectation below is checked too
    result_t     want;
  } stim_row_t;

  // predictor state: sorted disjoint ranges
  logic [31:0] span_lo[drt_pkg::MaxRanges];
  logic [31:0] span_hi[drt_pkg::MaxRanges];
  int          span_count;

  result_t pending_results[$];
  int      mismatches;
  int      watchdog;
  int      send_idle_pct;
  int      recv_idle_pct;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] end_of(logic [31:0] s, logic [31:0] len);
    logic [32:0] sum;
    sum = {1'b0, s} + {1'b0, len};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // bring the tracker model one word forward, return its result
  function automatic result_t track_range_op(logic [1:0] op, logic [31:0] s,
                                             logic [31:0] len, logic [31:0] lim);
    result_t     r;
    logic [31:0] e;
    logic [31:0] ns;
    logic [31:0] ne;
    int          first;
    int          last;
    int          pos;
    int          gap;
    bit          done;
    r = '0;
    e = end_of(s, len);
    first = -1;
    last = -1;
    done = 0;
    case (op)
      drt_pkg::OpAdd: begin
        if (e != s) begin
          for (int k = 0; k < span_count; k++)
            if (span_lo[k] <= e && span_hi[k] >= s) begin
              if (first < 0) first = k;
              last = k;
            end
          if (first >= 0) begin
            // collapse every touched entry into the first slot
            ns = span_lo[first] < s ? span_lo[first] : s;
            ne = span_hi[last] > e ? span_hi[last] : e;
            gap = last - first;
            span_lo[first] = ns;
            span_hi[first] = ne;
            for (int k = last + 1; k < span_count; k++) begin
              span_lo[k - gap] = span_lo[k];
              span_hi[k - gap] = span_hi[k];
            end
            span_count -= gap;
          end else if (span_count >= drt_pkg::MaxRanges) begin
            r.table_full = 1'b1;
          end else begin
            pos = span_count;
            for (int k = 0; k < span_count; k++)
              if (span_lo[k] > s && pos == span_count) pos = k;
            for (int k = span_count; k > pos; k--) begin
              span_lo[k] = span_lo[k - 1];
              span_hi[k] = span_hi[k - 1];
            end
            span_lo[pos] = s;
            span_hi[pos] = e;
            span_count++;
          end
        end
      end
      drt_pkg::OpMatch: begin
        for (int k = 0; k < span_count && !done; k++) begin
          if (span_lo[k] <= s && e <= span_hi[k]) begin
            r.covered = 1'b1;
            done = 1;
          end else if (span_lo[k] > s) begin
            done = 1;
          end
        end
      end
      drt_pkg::OpList: begin
        if (lim > s) begin
          for (int k = 0; k < span_count && !done; k++) begin
            if (span_lo[k] <= s && span_hi[k] > s) begin
              r.segment_length = (lim < span_hi[k] ? lim : span_hi[k]) - s;
              r.segment_marked = 1'b1;
              done = 1;
            end else if (span_lo[k] > s) begin
              r.segment_length = (lim < span_lo[k] ? lim : span_lo[k]) - s;
              done = 1;
            end
          end
          if (!done) r.segment_length = lim - s;
        end
      end
      default: span_count = 0;
    endcase
    r.range_count = span_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch (%s): expected cov=%0b len=%h mark=%0b full=%0b cnt=%0d,",
                " got cov=%0b len=%h mark=%0b full=%0b cnt=%0d"},
               $time, what, want.covered, want.segment_length, want.segment_marked,
               want.table_full, want.range_count, got.covered, got.segment_length,
               got.segment_marked, got.table_full, got.range_count);
  endtask

  // drive one word; held until the handshake, optional random gap first
  task automatic send_word(logic [1:0] op, logic [31:0] s, logic [31:0] len,
                           logic [31:0] lim, bit fixed, result_t want);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {lim, len, s};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = track_range_op(op, s, len, lim);
    if (fixed && pred !== want) report_mismatch("typed-in row vs predictor", want, pred);
    pending_results.push_back(pred);
    @(negedge clk);
  endtask

  // random address biased toward a small window so ranges collide
  function automatic logic [31:0] rand_addr();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(300);
      default: return $urandom_range(2000);
    endcase
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 0;
      default: return $urandom_range(40);
    endcase
  endfunction

  // sample results at the rising edge; ready changes at the falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", '0, result_t'(m_tdata[41:0]));
      end else if (result_t'(m_tdata[41:0]) !== pending_results[0]) begin
        report_mismatch("field", pending_results[0], result_t'(m_tdata[41:0]));
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog > 20000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [1:0] op, logic [31:0] s, logic [31:0] len,
                                    logic [31:0] lim, bit fixed, result_t want);
    stim_row_t r;
    r.op = op; r.start_req = s; r.length = len; r.limit_end = lim;
    r.fixed = fixed; r.want = want;
    return r;
  endfunction

  function automatic result_t cnt_only(int n);
    result_t r;
    r = '0;
    r.range_count = n[6:0];
    return r;
  endfunction

  initial begin
    result_t  w;
    logic [1:0] op;
    logic [31:0] base;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    m_tready = 1'b0;
    mismatches = 0;
    watchdog = 0;
    span_count = 0;
    send_idle_pct = 23;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: empty table, extremes, touching, containment, saturation
    w = '0; w.segment_length = 32'hFFFF_FFFF;
    directed.push_back(row(drt_pkg::OpMatch, 0, 0, 0, 1'b1, cnt_only(0)));
    directed.push_back(row(drt_pkg::OpList, 0, 0, 32'hFFFF_FFFF, 1'b1, w));
    directed.push_back(row(drt_pkg::OpList, 50, 0, 50, 1'b1, cnt_only(0))); // bound at start
    directed.push_back(row(drt_pkg::OpAdd, 100, 0, 0, 1'b1, cnt_only(0)));  // empty add
    directed.push_back(row(drt_pkg::OpAdd, 100, 10, 0, 1'b1, cnt_only(1)));
    directed.push_back(row(drt_pkg::OpAdd, 110, 5, 0, 1'b1, cnt_only(1)));  // touching right
    directed.push_back(row(drt_pkg::OpAdd, 90, 10, 0, 1'b1, cnt_only(1)));  // touching left
    directed.push_back(row(drt_pkg::OpAdd, 200, 10, 0, 1'b1, cnt_only(2)));
    directed.push_back(row(drt_pkg::OpAdd, 300, 10, 0, 1'b1, cnt_only(3)));
    directed.push_back(row(drt_pkg::OpAdd, 150, 300, 0, 1'b0, '0));   // contains two entries
    directed.push_back(row(drt_pkg::OpAdd, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 1'b0,
                           '0));                                      // saturated end
    directed.push_back(row(drt_pkg::OpMatch, 95, 10, 0, 1'b0, '0));
    directed.push_back(row(drt_pkg::OpMatch, 115, 0, 0, 1'b0, '0));   // zero-length at end
    directed.push_back(row(drt_pkg::OpMatch, 100, 60, 0, 1'b0, '0));
    directed.push_back(row(drt_pkg::OpList, 95, 0, 1000, 1'b0, '0));
    directed.push_back(row(drt_pkg::OpList, 120, 0, 1000, 1'b0, '0));
    directed.push_back(row(drt_pkg::OpList, 0, 0, 32'hFFFF_FFFF, 1'b0, '0));
    directed.push_back(row(drt_pkg::OpList, 32'hFFFF_FFF0, 0, 32'hFFFF_FFFF, 1'b0, '0));
    directed.push_back(row(drt_pkg::OpClear, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           1'b1, cnt_only(0)));
    foreach (directed[i])
      send_word(directed[i].op, directed[i].start_req, directed[i].length,
                directed[i].limit_end, directed[i].fixed, directed[i].want);

    // fill the table past its size so the overflow flag shows up
    for (int i = 0; i < drt_pkg::MaxRanges + 2; i++)
      send_word(drt_pkg::OpAdd, 32'(i * 4), 2, 0, 1'b0, '0);
    send_word(drt_pkg::OpList, 3, 0, 32'hFFFF_FFFF, 1'b0, '0);
    send_word(drt_pkg::OpAdd, 0, 32'hFFFF_FFFF, 0, 1'b0, '0);   // swallows everything
    send_word(drt_pkg::OpClear, 0, 0, 0, 1'b0, '0);

    // random part in three idling phases
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 23 : (p == 1) ? 71 : 0;
      recv_idle_pct = (p == 0) ? 71 : (p == 1) ? 23 : 0;
      for (int i = 0; i < 82; i++) begin
        case ($urandom_range(99)) inside
          [0:54]:  op = drt_pkg::OpAdd;
          [55:74]: op = drt_pkg::OpMatch;
          [75:96]: op = drt_pkg::OpList;
          default: op = drt_pkg::OpClear;
        endcase
        base = rand_addr();
        send_word(op, base, rand_len(),
                  ($urandom_range(3) == 0) ? $urandom() : base + $urandom_range(200),
                  1'b0, '0);
      end
      // dense burst of short adds into a cleared table
      send_word(drt_pkg::OpClear, 0, 0, 0, 1'b0, '0);
      for (int i = 0; i < 70; i++)
        send_word(drt_pkg::OpAdd, $urandom_range(700) * 3, $urandom_range(1), 0, 1'b0, '0);
      send_word(drt_pkg::OpMatch, $urandom_range(2000), $urandom_range(3), 0, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ dirty_range_tracker.f @@
src/drt_pkg.sv
src/drt_ctrl.sv
src/drt_dp.sv
src/dirty_range_tracker.sv
test/testbench.sv
